/* hw/rtl/anp_pkg.sv */
// ----------------------------------------------------------------------------
// anp_pkg
// Shared types, field offsets and header constants for the Art-Net parser.
// ----------------------------------------------------------------------------
package anp_pkg;

   // Header layout (byte positions within the UDP payload)
   localparam logic [15:0] ID_LEN          = 16'd7;
   localparam logic [15:0] TERM_POS        = 16'd7;
   localparam logic [15:0] OPCODE_LO_POS   = 16'd8;
   localparam logic [15:0] OPCODE_HI_POS   = 16'd9;
   localparam logic [15:0] UNIVERSE_LO_POS = 16'd14;
   localparam logic [15:0] UNIVERSE_HI_POS = 16'd15;
   localparam logic [15:0] LENGTH_HI_POS   = 16'd16;
   localparam logic [15:0] LENGTH_LO_POS   = 16'd17;
   localparam logic [15:0] PAYLOAD_OFFSET  = 16'd18;
   // Position of the last byte of a packet that just reaches the minimum length
   localparam logic [15:0] MIN_LAST_POS    = 16'd11;
   localparam logic [15:0] POS_MAX         = 16'hffff;
   localparam logic [7:0]  TERM_BYTE       = 8'h00;

   localparam logic [15:0] DMX_OPCODE_RESET = 16'h5000;

   // Result kinds (travel on tuser)
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Register map
   localparam logic [0:0] REG_DMX_OPCODE = 1'd0;

   // Result word layout on rsp_tdata, lowest bit up
   localparam int RSP_DATA_W  = 80;
   localparam int VALUE_LSB   = 0;
   localparam int INDEX_LSB   = 8;
   localparam int UNIV_LSB    = 24;
   localparam int HV_BIT      = 40;
   localparam int DMX_BIT     = 41;
   localparam int OPCODE_LSB  = 42;
   localparam int COUNT_LSB   = 58;
   localparam int PAD_LSB     = 74;

   typedef struct packed {
      logic        kind;
      logic [7:0]  dmx_value;
      logic [15:0] channel_index;
      logic [15:0] universe_out;
      logic        header_valid;
      logic        is_dmx;
      logic [15:0] opcode_out;
      logic [15:0] payload_count;
   } anp_result_type;

   // Up to two results leave the parser for one byte
   typedef struct packed {
      logic           first_valid;
      logic           second_valid;
      anp_result_type first;
      anp_result_type second;
   } anp_push_type;

   // Expected "Art-Net" text
   function automatic logic [7:0] anp_id_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h41;
         3'd1:    c = 8'h72;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h2d;
         3'd4:    c = 8'h4e;
         3'd5:    c = 8'h65;
         3'd6:    c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

/* hw/rtl/anp_parse.sv */
// ----------------------------------------------------------------------------
// anp_parse
// Per-packet header state and byte decode; turns one registered byte into
// up to two results (payload value, then end-of-packet summary).
// ----------------------------------------------------------------------------
module anp_parse import anp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         byte_valid,
   input  logic [7:0]   byte_data,
   input  logic         byte_last,
   input  logic [15:0]  cfg_opcode,
   output anp_push_type push
);

   logic [15:0] pos_ff,  pos_in;
   logic        hg_ff,   hg_in;
   logic [15:0] op_ff,   op_in;
   logic [15:0] uni_ff,  uni_in;
   logic [15:0] len_ff,  len_in;
   logic [15:0] cnt_ff,  cnt_in;

   logic        emit;
   logic [15:0] cnt_step;
   logic        hv;
   logic        dmx;
   logic [15:0] sum_uni;
   logic [15:0] sum_op;

   anp_result_type pay_res;
   anp_result_type sum_res;

   // Decode the byte against its position and update the packet state
   always_comb begin
      pos_in   = pos_ff;
      hg_in    = hg_ff;
      op_in    = op_ff;
      uni_in   = uni_ff;
      len_in   = len_ff;
      cnt_step = cnt_ff;
      emit     = 1'b0;

      if (pos_ff < ID_LEN) begin
         if (byte_data != anp_id_char(pos_ff[2:0])) begin
            hg_in = 1'b0;
         end
      end else begin
         case (pos_ff)
            TERM_POS: begin
               if (byte_data != TERM_BYTE) begin
                  hg_in = 1'b0;
               end
            end
            OPCODE_LO_POS:   op_in  = {op_ff[15:8], byte_data};
            OPCODE_HI_POS:   op_in  = {byte_data, op_ff[7:0]};
            UNIVERSE_LO_POS: uni_in = {uni_ff[15:8], byte_data};
            UNIVERSE_HI_POS: uni_in = {byte_data, uni_ff[7:0]};
            LENGTH_HI_POS:   len_in = {byte_data, len_ff[7:0]};
            LENGTH_LO_POS:   len_in = {len_ff[15:8], byte_data};
            default: begin
               if (pos_ff >= PAYLOAD_OFFSET && hg_ff && op_ff == cfg_opcode
                   && cnt_ff < len_ff) begin
                  emit     = 1'b1;
                  cnt_step = cnt_ff + 16'd1;
               end
            end
         endcase
      end

      if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + 16'd1;
      end
      cnt_in = cnt_step;

      // Summary sees the state after this byte but before the clear
      hv      = hg_in && (pos_ff >= MIN_LAST_POS);
      dmx     = hv && (op_in == cfg_opcode);
      sum_uni = dmx ? uni_in : '0;
      sum_op  = hv ? op_in : '0;

      // Packet ends: back to the idle values
      if (byte_last) begin
         pos_in = '0;
         hg_in  = 1'b1;
         op_in  = '0;
         uni_in = '0;
         len_in = '0;
         cnt_in = '0;
      end
   end

   // Build the result words
   always_comb begin
      pay_res.kind          = KIND_PAYLOAD;
      pay_res.dmx_value     = byte_data;
      pay_res.channel_index = cnt_ff;
      pay_res.universe_out  = uni_ff;
      pay_res.header_valid  = 1'b1;
      pay_res.is_dmx        = 1'b1;
      pay_res.opcode_out    = op_ff;
      pay_res.payload_count = '0;

      sum_res.kind          = KIND_SUMMARY;
      sum_res.dmx_value     = '0;
      sum_res.channel_index = '0;
      sum_res.universe_out  = sum_uni;
      sum_res.header_valid  = hv;
      sum_res.is_dmx        = dmx;
      sum_res.opcode_out    = sum_op;
      sum_res.payload_count = cnt_step;
   end

   // Order results: payload first, summary after it
   always_comb begin
      push.first_valid  = byte_valid && (emit || byte_last);
      push.second_valid = byte_valid && emit && byte_last;
      push.first        = emit ? pay_res : sum_res;
      push.second       = sum_res;
   end

   // Hold packet state between bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         hg_ff  <= 1'b1;
         op_ff  <= '0;
         uni_ff <= '0;
         len_ff <= '0;
         cnt_ff <= '0;
      end else if (byte_valid) begin
         pos_ff <= pos_in;
         hg_ff  <= hg_in;
         op_ff  <= op_in;
         uni_ff <= uni_in;
         len_ff <= len_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hw/rtl/anp_rsp_queue.sv */
// ----------------------------------------------------------------------------
// anp_rsp_queue
// Result queue: takes up to two results a cycle, hands out one word a cycle while pop is high.
// ----------------------------------------------------------------------------
module anp_rsp_queue import anp_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  anp_push_type               push,
   input  logic                       pop,
   output anp_result_type             head,
   output logic                       head_valid,
   output logic [$clog2(DEPTH):0]     level
);

   localparam int PTR_W = $clog2(DEPTH);

   anp_result_type     mem_ff [DEPTH];
   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic [PTR_W-1:0]   rp_ff, rp_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;
   logic [PTR_W-1:0]   wp_next;
   logic [PTR_W:0]     n_push;

   always_comb begin
      wp_next = wp_ff + PTR_W'(1);
      n_push  = (PTR_W+1)'(push.first_valid) + (PTR_W+1)'(push.second_valid);
      wp_in   = wp_ff + n_push[PTR_W-1:0];
      rp_in   = pop ? rp_ff + PTR_W'(1) : rp_ff;
      cnt_in  = cnt_ff + n_push - (PTR_W+1)'(pop);
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Write up to two entries
   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[wp_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem_ff[wp_next] <= push.second;
      end
   end

   assign head       = mem_ff[rp_ff];
   assign head_valid = (cnt_ff != '0);
   assign level      = cnt_ff;

endmodule

/* hw/rtl/artnet_packet_parser_unit.sv */
// ----------------------------------------------------------------------------
// artnet_packet_parser_unit
// Art-Net ArtDmx receive parser: one UDP payload byte per word in, DMX
// values and one end-of-packet summary per packet out.
// ----------------------------------------------------------------------------
// Takes one payload byte per clock while req_tready is high. A byte passes an
// input register, is decoded against its position in the packet and written
// into a result queue of QUEUE_DEPTH words that feeds the rsp_ side. The last
// byte of a packet that also carries a DMX value yields two words (value,
// then summary), all other bytes at most one; the rsp_ side drains one word
// per cycle while rsp_tready is high. req_tready drops only when the queue
// could not take two more words for every byte in flight, so with rsp_tready
// held high and QUEUE_DEPTH 8 input runs at one byte per cycle. dmx_opcode is
// at byte address 0 of the csr_ port and should be written between packets.
// ----------------------------------------------------------------------------
module artnet_packet_parser_unit import anp_pkg::*; #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input bytes
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] rx_byte
   input  logic                   req_tlast,   // end_of_packet
   // Results
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] dmx_value, [23:8] channel_index, [39:24] universe_out,
   // [40] header_valid, [41] is_dmx, [57:42] opcode_out,
   // [73:58] payload_count, [79:74] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic [0:0]             rsp_tuser,   // [0] result_kind
   // Configuration
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int LVL_W = $clog2(QUEUE_DEPTH) + 1;

   logic [15:0]      dmx_opcode_ff;
   logic             s0_valid_ff;
   logic [7:0]       s0_byte_ff;
   logic             s0_last_ff;
   anp_push_type     push;
   anp_result_type   head;
   logic             head_valid;
   logic [LVL_W-1:0] level;
   logic [LVL_W+1:0] need;
   logic             csr_sel_reg;

   // Register file
   assign csr_pready  = 1'b1;
   assign csr_sel_reg = (csr_paddr[2:2] == REG_DMX_OPCODE) && (csr_paddr[1:0] == 2'd0);
   assign csr_prdata  = csr_sel_reg ? {16'd0, dmx_opcode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dmx_opcode_ff <= DMX_OPCODE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_reg) begin
         dmx_opcode_ff <= csr_pwdata[15:0];
      end
   end

   // Accept only when the queue has room for two words per byte in flight
   always_comb begin
      need       = (LVL_W+2)'(level) + (s0_valid_ff ? (LVL_W+2)'(2) : '0) + (LVL_W+2)'(2);
      req_tready = (need <= (LVL_W+2)'(QUEUE_DEPTH));
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= req_tvalid && req_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s0_byte_ff <= req_tdata;
         s0_last_ff <= req_tlast;
      end
   end

   anp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (s0_valid_ff),
      .byte_data  (s0_byte_ff),
      .byte_last  (s0_last_ff),
      .cfg_opcode (dmx_opcode_ff),
      .push       (push)
   );

   anp_rsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tvalid && rsp_tready),
      .head       (head),
      .head_valid (head_valid),
      .level      (level)
   );

   // Pack the result word
   assign rsp_tvalid   = head_valid;
   assign rsp_tuser[0] = head.kind;
   assign rsp_tdata    = {6'd0, head.payload_count, head.opcode_out, head.is_dmx,
                          head.header_valid, head.universe_out, head.channel_index,
                          head.dmx_value};

endmodule

/* hw/rtl/anp_checker.sv */
// ----------------------------------------------------------------------------
// anp_checker
// Port-level checks on the parser's result stream.
// ----------------------------------------------------------------------------
module anp_checker import anp_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]            rsp_tuser
);

   // Queue comes out of reset empty
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // DMX value words always come from a good DMX header and carry no count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == KIND_PAYLOAD |->
         rsp_tdata[HV_BIT] && rsp_tdata[DMX_BIT]
         && rsp_tdata[COUNT_LSB +: 16] == 16'd0)
      else $error("payload word with bad flags");

   // Summary: no value or index, no opcode or DMX flag without a valid header
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == KIND_SUMMARY |->
         rsp_tdata[INDEX_LSB-1:VALUE_LSB] == 8'd0
         && rsp_tdata[UNIV_LSB-1:INDEX_LSB] == 16'd0
         && (rsp_tdata[HV_BIT] || rsp_tdata[OPCODE_LSB +: 16] == 16'd0)
         && (!rsp_tdata[DMX_BIT] || rsp_tdata[HV_BIT]))
      else $error("summary word inconsistent");

   // Padding stays zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:PAD_LSB] == '0)
      else $error("result padding not zero");

endmodule

bind artnet_packet_parser_unit anp_checker u_anp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
